/* sv/otws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave tuner wiper step package
// Shared widths, reset values, action and register codes, and the structs
// that travel between the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package otws_pkg;

  localparam int FREQ_BITS_DEF = 24;
  localparam int FRAC_BITS     = 8;
  localparam int BASE_W        = 16;
  localparam int BAND_W        = 24;
  localparam int STEP_W        = 8;
  localparam int WIPER_W       = 8;
  localparam int ACT_W         = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  // Command queue depth; must be a power of two so the pointers wrap.
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);

  // Base frequency resets to 55/32 Hz in fixed point.
  localparam logic [BASE_W-1:0]  BASE_RESET        = BASE_W'((55 << FRAC_BITS) / 32);
  localparam logic [BAND_W-1:0]  FINE_BAND_RESET   = BAND_W'(128);
  localparam logic [BAND_W-1:0]  COARSE_BAND_RESET = BAND_W'(2560);
  localparam logic [STEP_W-1:0]  FINE_STEP_RESET   = STEP_W'(1);
  localparam logic [STEP_W-1:0]  COARSE_STEP_RESET = STEP_W'(10);
  localparam logic [WIPER_W-1:0] WIPER_RESET       = WIPER_W'(128);
  localparam logic [WIPER_W-1:0] WIPER_MAX         = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_HOLD      = 3'd0,
    ACT_FINE_DN   = 3'd1,
    ACT_FINE_UP   = 3'd2,
    ACT_COARSE_DN = 3'd3,
    ACT_COARSE_UP = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_FREQ   = 3'd0,
    REG_FINE_BAND   = 3'd1,
    REG_COARSE_BAND = 3'd2,
    REG_FINE_STEP   = 3'd3,
    REG_COARSE_STEP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_freq;
    logic [BAND_W-1:0] fine_band;
    logic [BAND_W-1:0] coarse_band;
    logic [STEP_W-1:0] fine_step;
    logic [STEP_W-1:0] coarse_step;
  } cfg_t;

  // Classified wiper command handed from the front end to the back end.
  typedef struct packed {
    action_t           action;
    logic              above;
    logic [STEP_W-1:0] step;
  } step_cmd_t;

endpackage

/* sv/octave_tuner_wiper_step_unit.sv */
`timescale 1ns / 1ps
// A result passes the two front-end stages, the 4-entry queue and the output register.
// Throughput while out_stall is low: one transaction per cycle; the front end squares and
// searches octaves in a two-stage pipeline; the back end updates the wiper once per cycle.
// Reset: synchronous active-low rst_n restores the register defaults, sets the wiper to
// mid scale and empties every pipeline stage and the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
// Octave tuner wiper step unit
// Finds the nearest octave of the base frequency for each measured frequency
// and steps a saturating potentiometer wiper toward it.
// ----------------------------------------------------------------------------
module octave_tuner_wiper_step_unit #(
  parameter int FREQ_BITS = otws_pkg::FREQ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Frequency input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [FREQ_BITS-1:0]              in_frequency,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [otws_pkg::WIPER_W-1:0]      out_wiper_value,
  output logic [FREQ_BITS-1:0]              out_target_freq,
  output logic [otws_pkg::ACT_W-1:0]        out_action,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [otws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [otws_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import otws_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 q_full;
  logic                 q_empty;
  logic                 push;
  logic                 pop;
  logic [FREQ_BITS-1:0] push_target;
  logic [FREQ_BITS-1:0] head_target;
  step_cmd_t            push_cmd;
  step_cmd_t            head_cmd;

  // Configuration writes are always taken; the user must write them only while the
  // datapath is idle (the block does not enforce it), as the registers feed all stages directly.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_FREQ:   cfg_nxt.base_freq   = cfg_wdata[BASE_W-1:0];
        REG_FINE_BAND:   cfg_nxt.fine_band   = cfg_wdata[BAND_W-1:0];
        REG_COARSE_BAND: cfg_nxt.coarse_band = cfg_wdata[BAND_W-1:0];
        REG_FINE_STEP:   cfg_nxt.fine_step   = cfg_wdata[STEP_W-1:0];
        REG_COARSE_STEP: cfg_nxt.coarse_step = cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_freq   <= BASE_RESET;
      cfg_r.fine_band   <= FINE_BAND_RESET;
      cfg_r.coarse_band <= COARSE_BAND_RESET;
      cfg_r.fine_step   <= FINE_STEP_RESET;
      cfg_r.coarse_step <= COARSE_STEP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: square, octave search and error classification.
  otws_front #(.FREQ_BITS(FREQ_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_frequency (in_frequency),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .push         (push),
    .push_target  (push_target),
    .push_cmd     (push_cmd)
  );

  // The queue lets the front end keep accepting while the result is stalled.
  otws_queue #(.FREQ_BITS(FREQ_BITS)) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .push_target (push_target),
    .push_cmd    (push_cmd),
    .full        (q_full),
    .pop         (pop),
    .empty       (q_empty),
    .head_target (head_target),
    .head_cmd    (head_cmd)
  );

  // Back end: the wiper state and the output register.
  otws_back #(.FREQ_BITS(FREQ_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .head_target     (head_target),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_wiper_value (out_wiper_value),
    .out_target_freq (out_target_freq),
    .out_action      (out_action)
  );

endmodule

/* sv/otws_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave tuner front end
// Accepts frequencies, finds the nearest octave target and classifies the
// error into a wiper command that is pushed into the command queue.
// ----------------------------------------------------------------------------
module otws_front #(
  parameter int FREQ_BITS = otws_pkg::FREQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  otws_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  input  logic [FREQ_BITS-1:0]  in_frequency,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  push,
  output logic [FREQ_BITS-1:0]  push_target,
  output otws_pkg::step_cmd_t   push_cmd
);
  import otws_pkg::*;

  localparam int PROD_W = 2 * FREQ_BITS;
  localparam int SQB_W  = 2 * BASE_W;
  localparam int EW     = (FREQ_BITS > BAND_W) ? FREQ_BITS : BAND_W;

  logic                 s1_v_r;
  logic [FREQ_BITS-1:0] s1_freq_r;
  logic [PROD_W-1:0]    s1_fsq_r;
  logic [SQB_W-1:0]     s1_bsq_r;
  logic                 s2_v_r;
  logic [FREQ_BITS-1:0] s2_freq_r;
  logic [FREQ_BITS-1:0] s2_target_r;

  logic                 s1_ready;
  logic                 s2_ready;
  logic                 accept;
  logic                 s1_adv;
  logic [FREQ_BITS-1:0] target_nxt;
  logic [PROD_W-1:0]    shifted;
  logic [PROD_W-1:0]    limit;

  logic                 above;
  logic [FREQ_BITS-1:0] err;
  logic [EW-1:0]        err_x;

  assign s2_ready = !s2_v_r || !q_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign s1_adv   = s1_v_r && s2_ready;
  assign accept   = in_valid && s1_ready;
  assign in_stall = !s1_ready;
  assign push     = s2_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // Squares are registered before the octave compare array.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_freq_r <= in_frequency;
      s1_fsq_r  <= PROD_W'(in_frequency) * PROD_W'(in_frequency);
      s1_bsq_r  <= SQB_W'(cfg.base_freq) * SQB_W'(cfg.base_freq);
    end
    if (s1_adv) begin
      s2_freq_r   <= s1_freq_r;
      s2_target_r <= target_nxt;
    end
  end

  // Doubling i is taken when base*2^(i+1) still fits and f*f >= 2*(base*2^i)^2.
  // Both tests are monotone in i, so the last passing doubling sets the target.
  always_comb begin
    target_nxt = FREQ_BITS'(cfg.base_freq);
    shifted    = '0;
    limit      = '0;
    for (int i = 0; i < FREQ_BITS; i++) begin
      shifted = PROD_W'(cfg.base_freq) << (i + 1);
      limit   = PROD_W'(s1_bsq_r) << (2 * i + 1);
      if ((shifted[PROD_W-1:FREQ_BITS] == '0) && (s1_fsq_r >= limit)) begin
        target_nxt = shifted[FREQ_BITS-1:0];
      end
    end
  end

  always_comb begin
    above       = s2_freq_r > s2_target_r;
    err         = above ? (s2_freq_r - s2_target_r) : (s2_target_r - s2_freq_r);
    err_x       = EW'(err);
    push_target = s2_target_r;
    push_cmd.above = above;
    if (err_x <= EW'(cfg.fine_band)) begin
      push_cmd.action = ACT_HOLD;
      push_cmd.step   = '0;
    end else if (err_x <= EW'(cfg.coarse_band)) begin
      push_cmd.action = above ? ACT_FINE_DN : ACT_FINE_UP;
      push_cmd.step   = cfg.fine_step;
    end else begin
      push_cmd.action = above ? ACT_COARSE_DN : ACT_COARSE_UP;
      push_cmd.step   = cfg.coarse_step;
    end
  end

endmodule

/* sv/otws_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave tuner command queue
// Small FIFO of classified wiper commands between front end and back end.
// ----------------------------------------------------------------------------
module otws_queue #(
  parameter int FREQ_BITS = otws_pkg::FREQ_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [FREQ_BITS-1:0]  push_target,
  input  otws_pkg::step_cmd_t   push_cmd,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output logic [FREQ_BITS-1:0]  head_target,
  output otws_pkg::step_cmd_t   head_cmd
);
  import otws_pkg::*;

  logic [FREQ_BITS-1:0] target_mem [QDEPTH];
  step_cmd_t            cmd_mem    [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r;
  logic [QPTR_W-1:0]    rd_ptr_r;
  logic [QPTR_W:0]      cnt_r;
  logic [QPTR_W:0]      cnt_nxt;

  assign full        = cnt_r == (QPTR_W + 1)'(QDEPTH);
  assign empty       = cnt_r == '0;
  assign head_target = target_mem[rd_ptr_r];
  assign head_cmd    = cmd_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      target_mem[wr_ptr_r] <= push_target;
      cmd_mem[wr_ptr_r]    <= push_cmd;
    end
  end

endmodule

/* sv/otws_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave tuner back end
// Applies queued commands to the wiper state with saturation and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module otws_back #(
  parameter int FREQ_BITS = otws_pkg::FREQ_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic [FREQ_BITS-1:0]              head_target,
  input  otws_pkg::step_cmd_t               head_cmd,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [otws_pkg::WIPER_W-1:0]      out_wiper_value,
  output logic [FREQ_BITS-1:0]              out_target_freq,
  output logic [otws_pkg::ACT_W-1:0]        out_action
);
  import otws_pkg::*;

  logic                 out_valid_r;
  logic [WIPER_W-1:0]   wiper_r;
  logic [WIPER_W-1:0]   wiper_nxt;
  logic [FREQ_BITS-1:0] out_target_r;
  action_t              out_action_r;
  logic [WIPER_W:0]     sum;

  assign pop             = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid       = out_valid_r;
  assign out_wiper_value = wiper_r;
  assign out_target_freq = out_target_r;
  assign out_action      = out_action_r;

  always_comb begin
    sum = (WIPER_W + 1)'(wiper_r) + (WIPER_W + 1)'(head_cmd.step);
    if (head_cmd.above) begin
      wiper_nxt = (WIPER_W'(head_cmd.step) > wiper_r) ? '0 : wiper_r - WIPER_W'(head_cmd.step);
    end else begin
      wiper_nxt = sum[WIPER_W] ? WIPER_MAX : sum[WIPER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wiper_r     <= WIPER_RESET;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        wiper_r     <= wiper_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_target_r <= head_target;
      out_action_r <= head_cmd.action;
    end
  end

endmodule

/* sv/otws_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave tuner port checker
// Watches the top-level ports and checks wiper movement against the action
// code, the stability of a stalled result and the range of the action code.
// ----------------------------------------------------------------------------
module otws_checker #(
  parameter int FREQ_BITS = otws_pkg::FREQ_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [otws_pkg::WIPER_W-1:0]      out_wiper_value,
  input logic [FREQ_BITS-1:0]              out_target_freq,
  input logic [otws_pkg::ACT_W-1:0]        out_action
);
  import otws_pkg::*;

  logic               out_take;
  logic [WIPER_W-1:0] last_wiper_r;

  assign out_take = out_valid && !out_stall;

  // Wiper value of the last delivered transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wiper_r <= WIPER_RESET;
    end else if (out_take) begin
      last_wiper_r <= out_wiper_value;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_wiper_value)
      && $stable(out_target_freq) && $stable(out_action))
    else $error("stalled result changed");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && (out_action == ACT_HOLD) |-> out_wiper_value == last_wiper_r)
    else $error("wiper moved on hold");

  a_up_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && ((out_action == ACT_FINE_UP) || (out_action == ACT_COARSE_UP))
      |-> out_wiper_value >= last_wiper_r)
    else $error("wiper moved down on an up action");

  a_down_moves_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && ((out_action == ACT_FINE_DN) || (out_action == ACT_COARSE_DN))
      |-> out_wiper_value <= last_wiper_r)
    else $error("wiper moved up on a down action");

  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_action <= ACT_COARSE_UP)
    else $error("undefined action code");

endmodule

bind octave_tuner_wiper_step_unit otws_checker #(.FREQ_BITS(FREQ_BITS)) u_otws_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_wiper_value (out_wiper_value),
  .out_target_freq (out_target_freq),
  .out_action      (out_action)
);

/* tb/sv/tb_octave_tuner_wiper_step_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave tuner wiper step unit testbench
// Drives measured frequencies through the unit under random idling and
// stalling. A behavioral model of the octave search, the band decision and
// the saturating wiper predicts every result, and each result is checked
// field by field. The run starts with a short directed table, then moves
// through several register settings with random frequency transactions.
// ----------------------------------------------------------------------------
module tb_octave_tuner_wiper_step_unit;
  import otws_pkg::*;

  localparam int FREQ_BITS = FREQ_BITS_DEF;
  localparam logic [63:0] FREQ_MASK = (64'd1 << FREQ_BITS) - 64'd1;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 115;
  // Percentage of cycles in which each side idles when not in a calm stretch.
  localparam int IDLE_PCT = 23;
  // Length of the receiver hold-off used to back the unit up into its input.
  localparam int HOLD_CYCLES = 64;
  // Cycles to wait after the last result.
  localparam int TAIL_CYCLES = 8;

  // One predicted result transaction.
  typedef struct packed {
    logic [WIPER_W-1:0]   wiper;
    logic [FREQ_BITS-1:0] target;
    action_t              action;
  } wiper_result_t;

  // One row of the directed table: either a register write or a frequency
  // transaction, the latter with an optional hand-written expected result.
  typedef struct packed {
    logic                 is_write;
    reg_idx_t             reg_sel;
    logic [CFG_DATA_W-1:0] value;
    logic                 known;
    wiper_result_t        result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FREQ_BITS-1:0]  in_frequency = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WIPER_W-1:0]    out_wiper_value;
  logic [FREQ_BITS-1:0]  out_target_freq;
  logic [ACT_W-1:0]      out_action;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BASE_FREQ;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Model state: the register file and the wiper as the unit should hold them.
  cfg_t               model_cfg;
  logic [WIPER_W-1:0] model_wiper;

  wiper_result_t expected_steps[$];
  directed_row_t directed_rows[$];

  int mismatches = 0;
  int items_sent = 0;
  int writes_done = 0;
  int results_checked = 0;

  // The main process raises hold_requests; the receiver process owns the
  // countdown, so each variable has exactly one writer.
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit calm_stretch = 1'b0;

  octave_tuner_wiper_step_unit #(
    .FREQ_BITS(FREQ_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_frequency(in_frequency),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_wiper_value(out_wiper_value),
    .out_target_freq(out_target_freq),
    .out_action(out_action),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: far above the slowest legal run, including every hold-off.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Predicts the result of one frequency and advances the model wiper.
  // The octave search doubles the target while the doubled value still fits
  // and the frequency sits at or above target*sqrt2, tested exactly as
  // f*f >= 2*t*t. A zero base never moves, so the target stays zero.
  function automatic wiper_result_t predict_wiper_step(input logic [FREQ_BITS-1:0] freq);
    logic [63:0]       f64;
    logic [63:0]       t;
    logic [63:0]       err;
    logic              above;
    logic [STEP_W-1:0] step;
    int                w;
    wiper_result_t     r;
    f64 = 64'(freq);
    t = 64'(model_cfg.base_freq);
    while (t != 0 && (t << 1) <= FREQ_MASK && f64 * f64 >= 64'd2 * t * t) t = t << 1;
    above = f64 > t;
    err = above ? f64 - t : t - f64;
    if (err <= 64'(model_cfg.fine_band)) begin
      step = '0;
      r.action = ACT_HOLD;
    end else if (err <= 64'(model_cfg.coarse_band)) begin
      step = model_cfg.fine_step;
      r.action = above ? ACT_FINE_DN : ACT_FINE_UP;
    end else begin
      step = model_cfg.coarse_step;
      r.action = above ? ACT_COARSE_DN : ACT_COARSE_UP;
    end
    // A frequency above its target pulls the wiper down, otherwise up.
    w = above ? int'(model_wiper) - int'(step) : int'(model_wiper) + int'(step);
    if (w < 0) w = 0;
    if (w > 255) w = 255;
    model_wiper = WIPER_W'(w);
    r.wiper = model_wiper;
    r.target = t[FREQ_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Result monitor: compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    wiper_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("result with nothing pending", 0, out_wiper_value);
      end else begin
        want = expected_steps.pop_front();
        results_checked++;
        if (out_wiper_value !== want.wiper)
          report_mismatch("wiper_value", want.wiper, out_wiper_value);
        if (out_target_freq !== want.target)
          report_mismatch("target_freq", want.target, out_target_freq);
        if (out_action !== want.action)
          report_mismatch("action", want.action, out_action);
      end
    end
  end

  // Result receiver: random stalls, a calm stretch without any, and a long
  // hold-off on request that fills the unit's internal queue.
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm_stretch && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Offers one frequency after a random gap and records its prediction once
  // the unit takes it. A hand-written result replaces the prediction in the
  // queue, but the model still advances so that later rows stay in step.
  task automatic send_freq(input logic [FREQ_BITS-1:0] freq, input logic known,
                           input wiper_result_t typed);
    wiper_result_t predicted;
    cfg_valid <= 1'b0;
    while (!calm_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_frequency <= freq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_wiper_step(freq);
    expected_steps.push_back(known ? typed : predicted);
    items_sent++;
  endtask

  // Waits with the input idle until every predicted result has come back.
  // It is only ever called right after an accepted transaction or when the
  // input is already idle, so in_valid never sees two updates in one step.
  task automatic drain_results();
    while (expected_steps.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Register write; cfg_valid stays high so back-to-back writes do not
  // toggle it within one step. The next frequency transaction lowers it.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_FREQ:   model_cfg.base_freq = data[BASE_W-1:0];
      REG_FINE_BAND:   model_cfg.fine_band = data[BAND_W-1:0];
      REG_COARSE_BAND: model_cfg.coarse_band = data[BAND_W-1:0];
      REG_FINE_STEP:   model_cfg.fine_step = data[STEP_W-1:0];
      REG_COARSE_STEP: model_cfg.coarse_step = data[STEP_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic configure(input cfg_t c);
    drain_results();
    write_reg(REG_BASE_FREQ, CFG_DATA_W'(c.base_freq));
    write_reg(REG_FINE_BAND, c.fine_band);
    write_reg(REG_COARSE_BAND, c.coarse_band);
    write_reg(REG_FINE_STEP, CFG_DATA_W'(c.fine_step));
    write_reg(REG_COARSE_STEP, CFG_DATA_W'(c.coarse_step));
  endtask

  // Directed table builders.
  task automatic table_item(input logic [FREQ_BITS-1:0] freq);
    directed_row_t row;
    row = '0;
    row.value = freq;
    directed_rows.push_back(row);
  endtask

  task automatic table_item_known(input logic [FREQ_BITS-1:0] freq,
                                  input logic [WIPER_W-1:0] wiper,
                                  input logic [FREQ_BITS-1:0] target, input action_t act);
    directed_row_t row;
    row = '0;
    row.value = freq;
    row.known = 1'b1;
    row.result.wiper = wiper;
    row.result.target = target;
    row.result.action = act;
    directed_rows.push_back(row);
  endtask

  task automatic table_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    directed_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_sel = idx;
    row.value = data;
    directed_rows.push_back(row);
  endtask

  // A span of random width, so that small and large values are both common.
  function automatic logic [23:0] rand_span();
    return 24'($urandom & ((32'd1 << $urandom_range(0, 24)) - 32'd1));
  endfunction

  // Register setting for each random phase: the defaults, both extremes,
  // then random settings with spans of every scale.
  function automatic cfg_t phase_setting(input int p);
    cfg_t c;
    case (p)
      0: begin
        c.base_freq = BASE_RESET;
        c.fine_band = FINE_BAND_RESET;
        c.coarse_band = COARSE_BAND_RESET;
        c.fine_step = FINE_STEP_RESET;
        c.coarse_step = COARSE_STEP_RESET;
      end
      1: begin
        c.base_freq = BASE_W'(1);
        c.fine_band = '0;
        c.coarse_band = '0;
        c.fine_step = '1;
        c.coarse_step = '1;
      end
      2: begin
        c.base_freq = '1;
        c.fine_band = '0;
        c.coarse_band = '1;
        c.fine_step = '1;
        c.coarse_step = '0;
      end
      default: begin
        c.base_freq = ($urandom_range(0, 7) == 0) ? '0 : BASE_W'(rand_span());
        c.fine_band = rand_span();
        c.coarse_band = c.fine_band + rand_span();
        c.fine_step = $urandom_range(0, 1) ? STEP_W'($urandom_range(0, 4))
                                           : STEP_W'($urandom_range(0, 255));
        c.coarse_step = $urandom_range(0, 1) ? STEP_W'($urandom_range(0, 24))
                                             : STEP_W'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  // Random frequency, half of them placed near an octave of the current base or
  // near the sqrt2 decision point between two octaves, where the band and
  // rounding decisions actually change; the rest spans the whole field.
  function automatic logic [FREQ_BITS-1:0] gen_freq();
    longint t;
    longint radius;
    longint f;
    int     k;
    int     kind;
    t = longint'(model_cfg.base_freq);
    k = $urandom_range(0, FREQ_BITS - 1);
    while (k > 0 && t != 0 && (t << 1) <= longint'(FREQ_MASK)) begin
      t = t << 1;
      k--;
    end
    kind = $urandom_range(0, 9);
    if (kind <= 3) begin
      radius = longint'(model_cfg.coarse_band);
      if (radius > 1048576) radius = 1048576;
      radius = radius + radius / 4 + 8;
      f = t + longint'($urandom_range(0, 32'(2 * radius))) - radius;
    end else if (kind == 4) begin
      f = ((t * 46341) >> 15) + longint'($urandom_range(0, 128)) - 64;
    end else if (kind <= 7) begin
      f = longint'(rand_span());
    end else if (kind == 8) begin
      case ($urandom_range(0, 2))
        0: f = 0;
        1: f = 1;
        default: f = longint'(FREQ_MASK);
      endcase
    end else begin
      f = longint'($urandom) & longint'(FREQ_MASK);
    end
    if (f < 0) f = 0;
    if (f > longint'(FREQ_MASK)) f = longint'(FREQ_MASK);
    return FREQ_BITS'(f);
  endfunction

  initial begin
    directed_row_t row;
    model_cfg.base_freq = BASE_RESET;
    model_cfg.fine_band = FINE_BAND_RESET;
    model_cfg.coarse_band = COARSE_BAND_RESET;
    model_cfg.fine_step = FINE_STEP_RESET;
    model_cfg.coarse_step = COARSE_STEP_RESET;
    model_wiper = WIPER_RESET;

    // Directed table. Starting from the reset defaults: exact base, zero
    // below the base, full scale in the top octave and an exact octave.
    table_item_known(24'd440, 8'd128, 24'd440, ACT_HOLD);
    table_item_known(24'd0, 8'd129, 24'd440, ACT_FINE_UP);
    table_item_known(24'hFFFFFF, 8'd119, 24'd14417920, ACT_COARSE_DN);
    table_item_known(24'd880, 8'd119, 24'd880, ACT_HOLD);
    // Both sides of the sqrt2 point between the first two octaves, then a
    // few ordinary frequencies.
    table_item(24'd622);
    table_item(24'd623);
    table_item(24'd1250);
    table_item(24'd3000000);
    // With a full coarse step the wiper saturates at both ends.
    table_write(REG_COARSE_STEP, 24'd255);
    table_item_known(24'hFFFFFF, 8'd0, 24'd14417920, ACT_COARSE_DN);
    table_item_known(24'hFFFFFF, 8'd0, 24'd14417920, ACT_COARSE_DN);
    table_item_known(24'd350000, 8'd255, 24'd450560, ACT_COARSE_UP);
    table_item_known(24'd350000, 8'd255, 24'd450560, ACT_COARSE_UP);
    // A zero base keeps the target at zero, so the error is the frequency.
    table_write(REG_BASE_FREQ, 24'd0);
    table_item_known(24'd0, 8'd255, 24'd0, ACT_HOLD);
    table_item_known(24'hFFFFFF, 8'd0, 24'd0, ACT_COARSE_DN);
    // Upper data bits beyond the base width are dropped, giving the largest
    // base; its top octave still fits the frequency field.
    table_write(REG_BASE_FREQ, 24'hFFFFFF);
    table_item_known(24'hFFFFFF, 8'd0, 24'd16776960, ACT_FINE_DN);
    table_item_known(24'd0, 8'd255, 24'd65535, ACT_COARSE_UP);
    // Widest and narrowest bands.
    table_write(REG_FINE_BAND, 24'hFFFFFF);
    table_item_known(24'd12345, 8'd255, 24'd65535, ACT_HOLD);
    table_write(REG_FINE_BAND, 24'd0);
    table_write(REG_COARSE_BAND, 24'd0);
    table_write(REG_FINE_STEP, 24'd0);
    table_item_known(24'd65536, 8'd0, 24'd65535, ACT_COARSE_DN);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        drain_results();
        write_reg(row.reg_sel, row.value);
      end else begin
        send_freq(row.value[FREQ_BITS-1:0], row.known, row.result);
      end
    end

    // Random phases, each under its own register setting. Phase two backs
    // the unit up with a long receiver hold-off while frequencies keep
    // coming, phase four runs without idling on either side, and phase six
    // pauses the sender mid-way until every result is back.
    for (int p = 0; p < PHASES; p++) begin
      configure(phase_setting(p));
      calm_stretch = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 10) hold_requests++;
        if (p == 6 && i == PHASE_ITEMS / 2) drain_results();
        send_freq(gen_freq(), 1'b0, '0);
      end
      calm_stretch = 1'b0;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d frequency transactions and %0d register writes over %0d settings.",
             items_sent, writes_done, PHASES + 1);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* octave_tuner_wiper_step_unit.f */
sv/otws_pkg.sv
sv/otws_front.sv
sv/otws_queue.sv
sv/otws_back.sv
sv/octave_tuner_wiper_step_unit.sv
sv/otws_checker.sv
tb/sv/tb_octave_tuner_wiper_step_unit.sv
